// ===== design/tksi_pkg.sv =====
// Shared types and constants for the top-k sorted insertion block.
// No dependencies; every other file of the block imports this package.
package tksi_pkg;

   // Default table depth
   localparam int CAPACITY_DEF = 10;

   // Fixed field widths
   localparam int SCORE_W = 32;
   localparam int TIME_W  = 32;
   localparam int NAME_LO_W = 64;
   localparam int NAME_HI_W = 48;
   localparam int IDX_W   = 4;
   localparam int RANK_W  = 4;

   // Operation codes
   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // One table entry as held in memory
   typedef struct packed {
      logic [SCORE_W-1:0]   score;
      logic [TIME_W-1:0]    play_time;
      logic [NAME_LO_W-1:0] name_low;
      logic [NAME_HI_W-1:0] name_high;
   } entry_type;

   // Input word
   typedef struct packed {
      logic                 opcode;
      logic [SCORE_W-1:0]   score;
      logic [TIME_W-1:0]    play_time;
      logic [NAME_LO_W-1:0] name_low;
      logic [NAME_HI_W-1:0] name_high;
      logic [IDX_W-1:0]     read_index;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [RANK_W-1:0]    rank;
      logic                 entry_valid;
      logic [SCORE_W-1:0]   entry_score;
      logic [TIME_W-1:0]    entry_time;
      logic [NAME_LO_W-1:0] entry_name_low;
      logic [NAME_HI_W-1:0] entry_name_high;
      logic [RANK_W-1:0]    entry_count;
   } rsp_word_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_PLACE,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

// ===== design/tksi_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on tksi_pkg for the word types.
interface tksi_req_if import tksi_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tksi_rsp_if import tksi_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/tksi_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
// Depends on tksi_pkg for the entry type.
module tksi_mem import tksi_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tksi_ctrl.sv =====
// Sequencer: walks the table from the bottom up, shifting entries down
// one per cycle through the memory, then places the new entry.
// Depends on tksi_pkg; drives the ports of tksi_mem.
module tksi_ctrl import tksi_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic          clock,
   input  logic          reset,
   // request side
   input  logic          req_valid,
   input  req_word_type  req_word,
   output logic          req_ready,
   // result side
   input  logic          res_free,
   output logic          res_load,
   output rsp_word_type  res_word,
   // memory ports
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output entry_type     wr_data,
   output logic [AW-1:0] rd_addr,
   input  entry_type     rd_data
);

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] hole_ff, hole_in;
   req_word_type word_ff, word_in;
   rsp_word_type res_ff, res_in;

   logic      accept;
   logic      idx_ok;
   logic      walk_stop;
   logic      hole_last;
   logic      not_full;
   entry_type new_entry;
   entry_type req_entry;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign idx_ok    = (CW'(0) + {{CW{1'b0}}, req_word.read_index}) <
                      ({{IDX_W{1'b0}}, count_ff});
   assign walk_stop = rd_data.score >= word_ff.score;
   assign hole_last = hole_ff == CW'(1);
   assign not_full  = count_ff < CW'(CAPACITY);

   assign new_entry = '{score: word_ff.score, play_time: word_ff.play_time,
                        name_low: word_ff.name_low, name_high: word_ff.name_high};
   assign req_entry = '{score: req_word.score, play_time: req_word.play_time,
                        name_low: req_word.name_low, name_high: req_word.name_high};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.opcode == OP_OFFER) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_WALK;
               end else begin
                  state_in = idx_ok ? ST_READ : ST_DONE;
               end
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               state_in = ST_DONE;
            end else if (hole_last) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_DONE;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      res_load  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = new_entry;
      rd_addr   = '0;
      count_in  = count_ff;
      hole_in   = hole_ff;
      word_in   = word_ff;
      res_in    = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               word_in = req_word;
               res_in  = '0;
               if (req_word.opcode == OP_OFFER) begin
                  if (count_ff == '0) begin
                     // empty table: entry goes straight to the top
                     wr_en       = 1'b1;
                     wr_addr     = '0;
                     wr_data     = req_entry;
                     count_in    = CW'(1);
                     res_in.rank = RANK_W'(1);
                  end else begin
                     // start at the lowest held entry
                     rd_addr = AW'(count_ff - CW'(1));
                     hole_in = count_ff;
                  end
               end else if (idx_ok) begin
                  rd_addr = AW'(req_word.read_index);
               end
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               if (hole_ff == count_ff) begin
                  // does not beat the lowest entry
                  res_in.rank = '0;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = AW'(hole_ff);
                  wr_data     = new_entry;
                  res_in.rank = RANK_W'(hole_ff + CW'(1));
                  if (not_full) begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end else begin
               // shift this entry down unless it falls off the end
               if (hole_ff < CW'(CAPACITY)) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(hole_ff);
                  wr_data = rd_data;
               end
               hole_in = hole_ff - CW'(1);
               if (!hole_last) begin
                  rd_addr = AW'(hole_ff - CW'(2));
               end
            end
         end
         ST_PLACE: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = new_entry;
            res_in.rank = RANK_W'(1);
            if (not_full) begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_READ: begin
            res_in.entry_valid     = 1'b1;
            res_in.entry_score     = rd_data.score;
            res_in.entry_time      = rd_data.play_time;
            res_in.entry_name_low  = rd_data.name_low;
            res_in.entry_name_high = rd_data.name_high;
         end
         ST_DONE: begin
            res_load = res_free;
         end
         default: begin
            res_load = 1'b0;
         end
      endcase
   end

   // Result word carries the count after this item
   always_comb begin
      res_word             = res_ff;
      res_word.entry_count = RANK_W'(count_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      word_ff <= word_in;
      res_ff  <= res_in;
   end

endmodule

// ===== design/top_k_sorted_insert_core.sv =====
// Top-k sorted insertion table. A read goes via ST_READ, skipping it when the
// index is past the count; an offer into an empty table goes to ST_DONE at once,
// else ST_WALK steps over held entries below the new position, one entry per
// cycle through the single read and write port of the memory. One word in flight
// at a time; a waiting result holds off the next word. Reset clears the count,
// sequencer and output valid only; entries past the count never read.
module top_k_sorted_insert_core import tksi_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic            clock,
   input  logic            reset,
   tksi_req_if.sink        req_bus,
   tksi_rsp_if.source      rsp_bus
);

   logic          res_free;
   logic          res_load;
   rsp_word_type  res_word;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;
   entry_type     rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   tksi_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tksi_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_word  (req_bus.payload),
      .req_ready (req_bus.ready),
      .res_free  (res_free),
      .res_load  (res_load),
      .res_word  (res_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Output register: slot frees when the held word is taken
   assign res_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_word_ff;

endmodule
